[sv/bpom_pkg.sv]
package bpom_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned AreaBits  = 2 * CoordBits;
  localparam int unsigned UniBits   = AreaBits + 1;
  localparam int unsigned RemBits   = UniBits + 1;
  localparam int unsigned QBits     = 17;
  localparam int unsigned ThrBits   = 17;
  localparam int unsigned AddrBits  = 3;

  localparam logic [ThrBits-1:0]   ThrReset = 17'd52429;
  localparam logic [CoordBits-1:0] OffReset = 12'd5;

  localparam logic RegThreshold = 1'b0;
  localparam logic RegOffset    = 1'b1;

  typedef struct packed {
    logic [CoordBits-1:0] a_x;
    logic [CoordBits-1:0] a_y;
    logic [CoordBits-1:0] a_w;
    logic [CoordBits-1:0] a_h;
    logic [CoordBits-1:0] b_x;
    logic [CoordBits-1:0] b_y;
    logic [CoordBits-1:0] b_w;
    logic [CoordBits-1:0] b_h;
  } bpom_in_t;

  typedef struct packed {
    logic [23:0] intersection_area;
    logic [24:0] union_area;
    logic [16:0] iou_ratio;
    logic [16:0] overlap_of_smaller;
    logic        boxes_similar;
    logic        a_inside_b;
    logic        both_large_enough;
  } bpom_out_t;

  typedef struct packed {
    logic                 pos_ok;
    logic                 a_in_b;
    logic                 wide_tall;
  } bpom_flags_t;

  typedef struct packed {
    logic [CoordBits-1:0] ow;
    logic [CoordBits-1:0] oh;
    logic [CoordBits-1:0] aw;
    logic [CoordBits-1:0] ah;
    logic [CoordBits-1:0] bw;
    logic [CoordBits-1:0] bh;
    bpom_flags_t          flags;
  } bpom_geo_t;

  typedef struct packed {
    logic [AreaBits-1:0] inter;
    logic [AreaBits-1:0] area_a;
    logic [AreaBits-1:0] area_b;
    bpom_flags_t         flags;
  } bpom_area_t;

  typedef struct packed {
    logic [AreaBits-1:0] inter;
    logic [UniBits-1:0]  uni;
    logic                az;
    logic                bz;
    logic                uz;
    bpom_flags_t         flags;
  } bpom_side_t;

  typedef struct packed {
    bpom_side_t          side;
    logic [RemBits-1:0]  r_u;
    logic [RemBits-1:0]  r_a;
    logic [RemBits-1:0]  r_b;
    logic [UniBits-1:0]  d_u;
    logic [AreaBits-1:0] d_a;
    logic [AreaBits-1:0] d_b;
    logic [QBits-1:0]    q_u;
    logic [QBits-1:0]    q_a;
    logic [QBits-1:0]    q_b;
  } bpom_div_t;

  function automatic logic [RemBits:0] bpom_step(logic [RemBits-1:0] r,
                                                 logic [UniBits-1:0] d);
    logic              ge;
    logic [RemBits-1:0] s;
    ge = (r >= {1'b0, d});
    s  = ge ? (r - {1'b0, d}) : r;
    return {ge, s[RemBits-2:0], 1'b0};
  endfunction

endpackage

[sv/bpom_prep.sv]
module bpom_prep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bpom_pkg::CoordBits-1:0] offset_i,
  input  logic                          valid_i,
  output logic                          take_o,
  input  bpom_pkg::bpom_in_t            word_i,
  output logic                          valid_o,
  input  logic                          take_i,
  output bpom_pkg::bpom_div_t           word_o
);

  localparam int unsigned CB = bpom_pkg::CoordBits;
  localparam int unsigned AB = bpom_pkg::AreaBits;
  localparam int unsigned UB = bpom_pkg::UniBits;
  localparam int unsigned RB = bpom_pkg::RemBits;

  logic [2:0] valid_q, valid_d;
  logic [2:0] take;
  bpom_pkg::bpom_geo_t  geo_q, geo_d;
  bpom_pkg::bpom_area_t area_q, area_d;
  bpom_pkg::bpom_div_t  div_q, div_d;

  logic [CB:0]   ax1, bx1, ay1, by1, x1, y1;
  logic [CB-1:0] x0, y0, dx, dy;
  logic [UB-1:0] uni;

  assign take[2] = !valid_q[2] || take_i;
  assign take[1] = !valid_q[1] || take[2];
  assign take[0] = !valid_q[0] || take[1];
  assign take_o  = take[0];

  assign valid_d[0] = take[0] ? valid_i    : valid_q[0];
  assign valid_d[1] = take[1] ? valid_q[0] : valid_q[1];
  assign valid_d[2] = take[2] ? valid_q[1] : valid_q[2];

  always_comb begin
    ax1 = {1'b0, word_i.a_x} + {1'b0, word_i.a_w};
    bx1 = {1'b0, word_i.b_x} + {1'b0, word_i.b_w};
    ay1 = {1'b0, word_i.a_y} + {1'b0, word_i.a_h};
    by1 = {1'b0, word_i.b_y} + {1'b0, word_i.b_h};
    x0  = (word_i.a_x > word_i.b_x) ? word_i.a_x : word_i.b_x;
    y0  = (word_i.a_y > word_i.b_y) ? word_i.a_y : word_i.b_y;
    x1  = (ax1 < bx1) ? ax1 : bx1;
    y1  = (ay1 < by1) ? ay1 : by1;
    dx  = (word_i.a_x > word_i.b_x) ? word_i.a_x - word_i.b_x : word_i.b_x - word_i.a_x;
    dy  = (word_i.a_y > word_i.b_y) ? word_i.a_y - word_i.b_y : word_i.b_y - word_i.a_y;
    geo_d.ow = (x1 > {1'b0, x0}) ? CB'(x1 - {1'b0, x0}) : '0;
    geo_d.oh = (y1 > {1'b0, y0}) ? CB'(y1 - {1'b0, y0}) : '0;
    geo_d.aw = word_i.a_w;
    geo_d.ah = word_i.a_h;
    geo_d.bw = word_i.b_w;
    geo_d.bh = word_i.b_h;
    geo_d.flags.pos_ok = (dx < offset_i) && (dy < offset_i);
    geo_d.flags.a_in_b = (word_i.a_x >= word_i.b_x) && (word_i.a_y >= word_i.b_y) &&
                         (ax1 <= bx1) && (ay1 <= by1);
    geo_d.flags.wide_tall = (word_i.a_w > CB'(1)) && (word_i.a_h > CB'(1)) &&
                            (word_i.b_w > CB'(1)) && (word_i.b_h > CB'(1));
  end

  always_comb begin
    area_d.inter  = AB'(geo_q.ow) * AB'(geo_q.oh);
    area_d.area_a = AB'(geo_q.aw) * AB'(geo_q.ah);
    area_d.area_b = AB'(geo_q.bw) * AB'(geo_q.bh);
    area_d.flags  = geo_q.flags;
  end

  always_comb begin
    uni = {1'b0, area_q.area_a} + {1'b0, area_q.area_b} - {1'b0, area_q.inter};
    div_d.side.inter = area_q.inter;
    div_d.side.uni   = uni;
    div_d.side.az    = (area_q.area_a == '0);
    div_d.side.bz    = (area_q.area_b == '0);
    div_d.side.uz    = (uni == '0);
    div_d.side.flags = area_q.flags;
    div_d.r_u = RB'(area_q.inter);
    div_d.r_a = RB'(area_q.inter);
    div_d.r_b = RB'(area_q.inter);
    div_d.d_u = uni;
    div_d.d_a = area_q.area_a;
    div_d.d_b = area_q.area_b;
    div_d.q_u = '0;
    div_d.q_a = '0;
    div_d.q_b = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[0] && valid_i) begin
      geo_q <= geo_d;
    end
    if (take[1] && valid_q[0]) begin
      area_q <= area_d;
    end
    if (take[2] && valid_q[1]) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q[2];
  assign word_o  = div_q;

endmodule

[sv/bpom_div_cell.sv]
module bpom_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                take_o,
  input  bpom_pkg::bpom_div_t word_i,
  output logic                valid_o,
  input  logic                take_i,
  output bpom_pkg::bpom_div_t word_o
);

  localparam int unsigned RB = bpom_pkg::RemBits;
  localparam int unsigned UB = bpom_pkg::UniBits;

  logic valid_q;
  bpom_pkg::bpom_div_t word_q, word_d;
  logic [RB:0] su, sa, sb;

  assign take_o = !valid_q || take_i;

  always_comb begin
    su = bpom_pkg::bpom_step(word_i.r_u, word_i.d_u);
    sa = bpom_pkg::bpom_step(word_i.r_a, UB'(word_i.d_a));
    sb = bpom_pkg::bpom_step(word_i.r_b, UB'(word_i.d_b));
    word_d     = word_i;
    word_d.r_u = su[RB-1:0];
    word_d.r_a = sa[RB-1:0];
    word_d.r_b = sb[RB-1:0];
    word_d.q_u = {word_i.q_u[bpom_pkg::QBits-2:0], su[RB]};
    word_d.q_a = {word_i.q_a[bpom_pkg::QBits-2:0], sa[RB]};
    word_d.q_b = {word_i.q_b[bpom_pkg::QBits-2:0], sb[RB]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[sv/bpom_post.sv]
module bpom_post (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bpom_pkg::ThrBits-1:0] threshold_i,
  input  logic                        valid_i,
  output logic                        take_o,
  input  bpom_pkg::bpom_div_t         word_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output bpom_pkg::bpom_out_t         word_o
);

  logic valid_q;
  bpom_pkg::bpom_out_t word_q, word_d;
  logic [bpom_pkg::QBits-1:0] fa, fb, fu;

  assign take_o = !valid_q || !stall_i;

  always_comb begin
    fu = word_i.side.uz ? '0 : word_i.q_u;
    fa = word_i.side.az ? '0 : word_i.q_a;
    fb = word_i.side.bz ? '0 : word_i.q_b;
    word_d.intersection_area  = word_i.side.inter;
    word_d.union_area         = word_i.side.uni;
    word_d.iou_ratio          = fu;
    word_d.overlap_of_smaller = (fa > fb) ? fa : fb;
    word_d.boxes_similar      = !word_i.side.az && !word_i.side.bz &&
                                (fa >= threshold_i) && (fb >= threshold_i) &&
                                word_i.side.flags.pos_ok;
    word_d.a_inside_b         = word_i.side.flags.a_in_b;
    word_d.both_large_enough  = word_i.side.flags.wide_tall;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[sv/box_pair_overlap_metrics_core.sv]
// Box pair overlap metrics: one box pair word in and one metrics word out per
// clock while stall_i is low, via three front stages (overlap extents, areas
// and union), a chain of 17 divider cells giving one quotient bit each for
// the IoU and both overlap fractions, and the output register. Bubbles in the
// chain are squeezed out, so words are taken while a result waits on stall_i.
module box_pair_overlap_metrics_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         stall_o,
  input  bpom_pkg::bpom_in_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         stall_i,
  output bpom_pkg::bpom_out_t          out_word_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpom_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned NCells = bpom_pkg::QBits;

  logic [bpom_pkg::ThrBits-1:0]   thr_q;
  logic [bpom_pkg::CoordBits-1:0] off_q;
  logic                           wr_en;

  logic                valid [NCells+1];
  logic                take  [NCells+1];
  bpom_pkg::bpom_div_t word  [NCells+1];
  logic                take_in;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= bpom_pkg::ThrReset;
      off_q <= bpom_pkg::OffReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        bpom_pkg::RegThreshold: thr_q <= pwdata[bpom_pkg::ThrBits-1:0];
        bpom_pkg::RegOffset:    off_q <= pwdata[bpom_pkg::CoordBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bpom_pkg::RegThreshold: prdata = 32'(thr_q);
      bpom_pkg::RegOffset:    prdata = 32'(off_q);
      default:                prdata = '0;
    endcase
  end

  assign stall_o = !take_in;

  bpom_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .offset_i (off_q),
    .valid_i  (in_valid_i),
    .take_o   (take_in),
    .word_i   (in_word_i),
    .valid_o  (valid[0]),
    .take_i   (take[0]),
    .word_o   (word[0])
  );

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    bpom_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .take_o  (take[i]),
      .word_i  (word[i]),
      .valid_o (valid[i+1]),
      .take_i  (take[i+1]),
      .word_o  (word[i+1])
    );
  end

  bpom_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (thr_q),
    .valid_i     (valid[NCells]),
    .take_o      (take[NCells]),
    .word_i      (word[NCells]),
    .valid_o     (out_valid_o),
    .stall_i     (stall_i),
    .word_o      (out_word_o)
  );

endmodule

[sv/bpom_checker.sv]
module bpom_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                stall_i,
  input bpom_pkg::bpom_out_t out_word_o,
  input logic                pready
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed under stall");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_iou_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.iou_ratio <= out_word_o.overlap_of_smaller)
    else $error("iou above overlap fraction");

  a_iou_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.intersection_area == '0 |->
      out_word_o.iou_ratio == '0)
    else $error("non-zero ratio without overlap");

endmodule

bind box_pair_overlap_metrics_core bpom_checker u_bpom_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .stall_i     (stall_i),
  .out_word_o  (out_word_o),
  .pready      (pready)
);

[verif/tb_top.sv]
module tb_top;

  localparam int unsigned Latency  = 21;
  localparam int unsigned WdLimit  = 2000;
  localparam logic [2:0]  AddrThr  = 3'd0;
  localparam logic [2:0]  AddrOff  = 3'd4;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       stall_o;
  bpom_pkg::bpom_in_t  in_word_i = '0;
  logic       out_valid_o;
  logic       stall_i = 1'b0;
  bpom_pkg::bpom_out_t out_word_o;
  logic       psel = 1'b0;
  logic       penable = 1'b0;
  logic       pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic       pready;

  box_pair_overlap_metrics_core dut (.*);

  always #6 clk_i = ~clk_i;

  logic [16:0] thr_q;
  logic [11:0] off_q;
  bpom_pkg::bpom_out_t metrics_due[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          stall_mode = 0;

  function automatic logic [16:0] q16_div(logic [63:0] num, logic [63:0] den);
    if (den == 0) return '0;
    return 17'((num << 16) / den);
  endfunction

  function automatic bpom_pkg::bpom_out_t overlap_metrics(bpom_pkg::bpom_in_t w);
    bpom_pkg::bpom_out_t r;
    logic [63:0] x0, y0, x1, y1, inter, aa, ab, uni, fa, fb, dx, dy;
    x0 = (w.a_x > w.b_x) ? w.a_x : w.b_x;
    y0 = (w.a_y > w.b_y) ? w.a_y : w.b_y;
    x1 = ((w.a_x + 64'(w.a_w)) < (w.b_x + 64'(w.b_w))) ? w.a_x + 64'(w.a_w) : w.b_x + 64'(w.b_w);
    y1 = ((w.a_y + 64'(w.a_h)) < (w.b_y + 64'(w.b_h))) ? w.a_y + 64'(w.a_h) : w.b_y + 64'(w.b_h);
    inter = (x1 > x0 && y1 > y0) ? (x1 - x0) * (y1 - y0) : 0;
    aa = 64'(w.a_w) * w.a_h;
    ab = 64'(w.b_w) * w.b_h;
    uni = aa + ab - inter;
    fa = q16_div(inter, aa);
    fb = q16_div(inter, ab);
    dx = (w.a_x > w.b_x) ? w.a_x - w.b_x : w.b_x - w.a_x;
    dy = (w.a_y > w.b_y) ? w.a_y - w.b_y : w.b_y - w.a_y;
    r.intersection_area = 24'(inter);
    r.union_area = 25'(uni);
    r.iou_ratio = (inter == 0) ? '0 : q16_div(inter, uni);
    r.overlap_of_smaller = 17'((fa > fb) ? fa : fb);
    r.boxes_similar = aa != 0 && ab != 0 && fa >= thr_q && fb >= thr_q &&
                      dx < off_q && dy < off_q;
    r.a_inside_b = w.a_x >= w.b_x && w.a_y >= w.b_y &&
                   w.a_x + 64'(w.a_w) <= w.b_x + 64'(w.b_w) &&
                   w.a_y + 64'(w.a_h) <= w.b_y + 64'(w.b_h);
    r.both_large_enough = w.a_w > 1 && w.a_h > 1 && w.b_w > 1 && w.b_h > 1;
    return r;
  endfunction

  // result checker and stall pattern
  always @(posedge clk_i) begin
    bpom_pkg::bpom_out_t e;
    if (rst_ni) begin
      if ((in_valid_i && !stall_o) || (out_valid_o && !stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !stall_i) begin
        if (metrics_due.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word_o);
          mismatches++;
        end else begin
          e = metrics_due.pop_front();
          if (e.intersection_area !== out_word_o.intersection_area)
            $display("%0t: inter exp %0d got %0d", $time, e.intersection_area, out_word_o.intersection_area);
          if (e.union_area !== out_word_o.union_area)
            $display("%0t: union exp %0d got %0d", $time, e.union_area, out_word_o.union_area);
          if (e.iou_ratio !== out_word_o.iou_ratio)
            $display("%0t: iou exp %0d got %0d", $time, e.iou_ratio, out_word_o.iou_ratio);
          if (e.overlap_of_smaller !== out_word_o.overlap_of_smaller)
            $display("%0t: ovl exp %0d got %0d", $time, e.overlap_of_smaller, out_word_o.overlap_of_smaller);
          if (e.boxes_similar !== out_word_o.boxes_similar)
            $display("%0t: similar exp %0d got %0d", $time, e.boxes_similar, out_word_o.boxes_similar);
          if (e.a_inside_b !== out_word_o.a_inside_b)
            $display("%0t: inside exp %0d got %0d", $time, e.a_inside_b, out_word_o.a_inside_b);
          if (e.both_large_enough !== out_word_o.both_large_enough)
            $display("%0t: large exp %0d got %0d", $time, e.both_large_enough, out_word_o.both_large_enough);
          if (e !== out_word_o) mismatches++;
        end
      end
      if (idle_cycles >= WdLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: stall_i <= 1'b0;
      1: stall_i <= ($urandom_range(0, 3) == 0);
      2: stall_i <= ($urandom_range(0, 1) == 0);
      default: stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic send_word(bpom_pkg::bpom_in_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_word_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    metrics_due.insert(metrics_due.size(), overlap_metrics(w));
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (metrics_due.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (a == AddrThr) thr_q = d[16:0]; else off_q = d[11:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic bpom_pkg::bpom_in_t box_pair(int ax, int ay, int aw, int ah,
                                                  int bx, int by, int bw, int bh);
    bpom_pkg::bpom_in_t w;
    w.a_x = 12'(ax); w.a_y = 12'(ay); w.a_w = 12'(aw); w.a_h = 12'(ah);
    w.b_x = 12'(bx); w.b_y = 12'(by); w.b_w = 12'(bw); w.b_h = 12'(bh);
    return w;
  endfunction

  function automatic bpom_pkg::bpom_in_t rand_pair();
    bpom_pkg::bpom_in_t w;
    int m;
    w = bpom_pkg::bpom_in_t'({$urandom, $urandom, $urandom});
    m = $urandom_range(0, 3);
    if (m != 0) begin
      // near-duplicate boxes so similarity and containment get exercised
      w.b_x = w.a_x + 12'($urandom_range(0, 8)) - 12'd4;
      w.b_y = w.a_y + 12'($urandom_range(0, 8)) - 12'd4;
      if (m == 1) begin
        w.a_w = 12'($urandom_range(0, 60)); w.a_h = 12'($urandom_range(0, 60));
      end
      w.b_w = w.a_w + 12'($urandom_range(0, 8)) - 12'd4;
      w.b_h = w.a_h + 12'($urandom_range(0, 8)) - 12'd4;
    end
    return w;
  endfunction

  task automatic test_directed;
    send_word(box_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_word(box_pair(0, 0, 4095, 4095, 0, 0, 4095, 4095));
    send_word(box_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    send_word(box_pair(0, 0, 4095, 4095, 4095, 4095, 4095, 4095));
    send_word(box_pair(10, 10, 20, 20, 12, 12, 20, 20));
    send_word(box_pair(10, 10, 20, 20, 30, 10, 20, 20));
    send_word(box_pair(10, 10, 0, 20, 10, 10, 20, 20));
    send_word(box_pair(10, 10, 20, 20, 10, 10, 20, 0));
    send_word(box_pair(12, 12, 5, 5, 10, 10, 20, 20));
    send_word(box_pair(10, 10, 1, 1, 10, 10, 1, 1));
    send_word(box_pair(10, 10, 2, 2, 10, 10, 2, 2));
    send_word(box_pair(0, 0, 4095, 1, 0, 0, 1, 4095));
    send_word(box_pair(14, 10, 20, 20, 10, 14, 20, 20));
    send_word(box_pair(15, 10, 20, 20, 10, 10, 20, 20));
    send_word(box_pair(4000, 4000, 4095, 4095, 4000, 4000, 4095, 4095));
    drain();
  endtask

  task automatic test_registers;
    logic [31:0] thr_set[5];
    logic [31:0] off_set[5];
    thr_set = '{32'd0, 32'd65536, 32'd65535, 32'd131071, 32'd52429};
    off_set = '{32'd0, 32'd4095, 32'd1, 32'd3, 32'd5};
    for (int i = 0; i < 5; i++) begin
      reg_write(AddrThr, thr_set[i]);
      reg_write(AddrOff, off_set[i]);
      for (int k = 0; k < 40; k++) send_word(rand_pair());
      send_word(box_pair(10, 10, 20, 20, 10, 10, 20, 20));
      drain();
    end
  endtask

  task automatic test_random;
    for (int k = 0; k < 200; k++) begin
      if (k == 100) drain();
      send_word(rand_pair());
    end
    drain();
  endtask

  initial begin
    thr_q = bpom_pkg::ThrReset;
    off_q = bpom_pkg::OffReset;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_registers();
    test_random();
    if (mismatches == 0 && metrics_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/bpom_pkg.sv
sv/bpom_prep.sv
sv/bpom_div_cell.sv
sv/bpom_post.sv
sv/box_pair_overlap_metrics_core.sv
sv/bpom_checker.sv
verif/tb_top.sv
